FILE: hdl/zosl_pkg.sv
// shared types and constants of the sorted entry table
`default_nettype none
package zosl_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_FIND   = 3'd2;
  localparam logic [2:0] FN_MOVE   = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;
  localparam logic [2:0] FN_LIST   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [15:0]       id;
    logic [15:0]       key;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/zosl_if.sv
// valid/ready channel interfaces for commands and results
`default_nettype none
interface zosl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [15:0]        item_id;
  logic signed [15:0] depth_key;

  modport source (output valid, func, item_id, depth_key, input ready);
  modport sink   (input valid, func, item_id, depth_key, output ready);
endinterface

interface zosl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic               entry_valid;
  logic [15:0]        entry_id;
  logic signed [15:0] entry_key;
  logic [5:0]         entry_count;
  logic               last;

  modport source (output valid, status, found, entry_valid, entry_id, entry_key,
                  entry_count, last, input ready);
  modport sink   (input valid, status, found, entry_valid, entry_id, entry_key,
                  entry_count, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/zosl_cell.sv
// one slot of the ordered table with its compare and neighbor shift
`default_nettype none
module zosl_cell
  import zosl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire cell_ctl_t        ctl,
  input  wire logic             left_m,
  input  wire logic             left_a,
  input  wire logic [15:0]      left_id,
  input  wire logic [15:0]      left_key,
  input  wire logic [15:0]      right_id,
  input  wire logic [15:0]      right_key,
  output logic                  m_o,
  output logic                  a_o,
  output logic [15:0]           id_r,
  output logic [15:0]           key_r
);

  logic        occ;
  logic        at_end;
  logic        gt;
  logic        hit;
  logic [15:0] id_nxt;
  logic [15:0] key_nxt;

  always_comb begin
    occ    = CNT_W'(cell_idx) < ctl.count;
    at_end = CNT_W'(cell_idx) == ctl.count;
    gt     = occ && ($signed(key_r) > $signed(ctl.key));
    // insertion region runs from the first greater key up to the first free slot
    m_o    = gt || at_end;
    hit    = occ && (id_r == ctl.id);
    // set from the first matching slot onward
    a_o    = left_a || hit;
    id_nxt  = id_r;
    key_nxt = key_r;
    if (ctl.ins && m_o) begin
      if (left_m) begin
        id_nxt  = left_id;
        key_nxt = left_key;
      end else begin
        id_nxt  = ctl.id;
        key_nxt = ctl.key;
      end
    end else if (ctl.rem && a_o && occ) begin
      id_nxt  = right_id;
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/z_ordered_sorted_list.sv
// top level: sorted entry table built from a chain of slot cells
// Keeps up to CAPACITY (id, signed key) entries in ascending key order.
// in_ch carries one command per transaction: insert, remove, find, move,
// clear or list. out_ch returns results with valid/ready; every command
// gives one result except list, which gives one per held entry (or one
// invalid result on an empty table), with last set on the final one.
// Sequence: a command is taken in the idle state, registered, and then
// executed by the state machine; move runs a remove pass then an insert
// pass through the cells, and list steps through the held entries, giving
// one result each.
// All slots compare against the command in parallel; the first match
// ripples along the cell chain, each slot finds the insertion region from
// its own compare, and each slot loads its left or right neighbor's entry.
// The next command is taken while the previous result still waits in the
// output register. A receiver stall holds the execute step, and the table,
// until the output register is free; a move's remove pass still goes ahead.
// Reset (rst_n low, synchronous) empties the table and drops any result.
`default_nettype none
module z_ordered_sorted_list
  import zosl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  zosl_in_if.sink     in_ch,
  zosl_out_if.source  out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_REM, S_INS, S_ONE, S_LIST} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [2:0]         func_r, func_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [15:0]        key_r, key_nxt;
  logic               had_r, had_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_evalid_r, out_evalid_nxt;
  logic [15:0]        out_eid_r, out_eid_nxt;
  logic [15:0]        out_ekey_r, out_ekey_nxt;
  logic [5:0]         out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  cell_ctl_t          ctl;
  logic               slot_free;
  logic               found_any;
  logic               not_full;
  logic               list_last;

  logic               c_m   [CAPACITY];
  logic               c_a   [CAPACITY];
  logic [15:0]        c_id  [CAPACITY];
  logic [15:0]        c_key [CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic        lm, la;
      logic [15:0] lid, lkey, rid, rkey;
      if (gi == 0) begin : g_first
        assign lm   = 1'b0;
        assign la   = 1'b0;
        assign lid  = '0;
        assign lkey = '0;
      end else begin : g_mid
        assign lm   = c_m[gi-1];
        assign la   = c_a[gi-1];
        assign lid  = c_id[gi-1];
        assign lkey = c_key[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_end
        assign rid  = c_id[gi];
        assign rkey = c_key[gi];
      end else begin : g_inner
        assign rid  = c_id[gi+1];
        assign rkey = c_key[gi+1];
      end
      zosl_cell u_cell (
        .clk       (clk),
        .cell_idx  (IDX_W'(gi)),
        .ctl       (ctl),
        .left_m    (lm),
        .left_a    (la),
        .left_id   (lid),
        .left_key  (lkey),
        .right_id  (rid),
        .right_key (rkey),
        .m_o       (c_m[gi]),
        .a_o       (c_a[gi]),
        .id_r      (c_id[gi]),
        .key_r     (c_key[gi])
      );
    end
  endgenerate

  assign found_any = c_a[CAPACITY-1];
  assign not_full  = count_r != CNT_W'(CAPACITY);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign list_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.entry_valid = out_evalid_r;
  assign out_ch.entry_id    = out_eid_r;
  assign out_ch.entry_key   = out_ekey_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.last        = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    func_nxt       = func_r;
    id_nxt         = id_r;
    key_nxt        = key_r;
    had_nxt        = had_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_evalid_nxt = out_evalid_r;
    out_eid_nxt    = out_eid_r;
    out_ekey_nxt   = out_ekey_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    ctl.ins   = 1'b0;
    ctl.rem   = 1'b0;
    ctl.id    = id_r;
    ctl.key   = key_r;
    ctl.count = count_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt = in_ch.func;
          id_nxt   = in_ch.item_id;
          key_nxt  = in_ch.depth_key;
          idx_nxt  = '0;
          had_nxt  = 1'b0;
          case (in_ch.func)
            FN_INSERT: state_nxt = S_INS;
            FN_MOVE:   state_nxt = S_REM;
            FN_LIST:   state_nxt = S_LIST;
            default:   state_nxt = S_ONE;
          endcase
        end
      end
      S_REM: begin
        // first half of a move: drop the first matching entry
        ctl.rem = found_any;
        had_nxt = found_any;
        if (found_any) begin
          count_nxt = count_r - CNT_W'(1);
        end
        state_nxt = S_INS;
      end
      S_INS: begin
        if (slot_free) begin
          ctl.ins = not_full;
          if (not_full) begin
            count_nxt = count_r + CNT_W'(1);
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = not_full ? ST_OK : ST_FULL;
          out_found_nxt  = (func_r == FN_MOVE) && had_r;
          out_evalid_nxt = 1'b0;
          out_eid_nxt    = '0;
          out_ekey_nxt   = '0;
          out_count_nxt  = 6'(count_nxt);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ONE: begin
        if (slot_free) begin
          out_status_nxt = ST_OK;
          out_found_nxt  = 1'b0;
          case (func_r)
            FN_REMOVE: begin
              ctl.rem        = found_any;
              out_found_nxt  = found_any;
              out_status_nxt = found_any ? ST_OK : ST_ABSENT;
              if (found_any) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            FN_FIND: begin
              out_found_nxt  = found_any;
              out_status_nxt = found_any ? ST_OK : ST_ABSENT;
            end
            FN_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
          out_valid_nxt  = 1'b1;
          out_evalid_nxt = 1'b0;
          out_eid_nxt    = '0;
          out_ekey_nxt   = '0;
          out_count_nxt  = 6'(count_nxt);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_found_nxt  = 1'b0;
          out_count_nxt  = 6'(count_r);
          if (count_r == '0) begin
            out_evalid_nxt = 1'b0;
            out_eid_nxt    = '0;
            out_ekey_nxt   = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            out_evalid_nxt = 1'b1;
            out_eid_nxt    = c_id[idx_r];
            out_ekey_nxt   = c_key[idx_r];
            out_last_nxt   = list_last;
            if (list_last) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      had_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      had_r       <= had_nxt;
      idx_r       <= idx_nxt;
    end
    func_r       <= func_nxt;
    id_r         <= id_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_evalid_r <= out_evalid_nxt;
    out_eid_r    <= out_eid_nxt;
    out_ekey_r   <= out_ekey_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REM |=> state_r == S_INS)
    else $error("move removal not followed by insertion");

  a_partial_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_evalid_r && state_r == S_LIST))
    else $error("non-final result outside a list");

  a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_evalid_r) |-> (out_status_r == ST_OK && !out_found_r))
    else $error("listed entry with non-ok status");

endmodule
`default_nettype wire

FILE: dv/tb_z_ordered_sorted_list.sv
// testbench for the sorted entry table: command streams checked against a table predictor
`timescale 1ns / 1ps
module tb_z_ordered_sorted_list
  import zosl_pkg::*;
;

  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam int NUM_CMDS    = 410;
  localparam int CALM_TAIL   = 60;
  localparam int SETTLE      = 50;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0]         func;
    logic [15:0]        item_id;
    logic signed [15:0] depth_key;
    bit                 drain;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic               entry_valid;
    logic [15:0]        entry_id;
    logic signed [15:0] entry_key;
    logic [5:0]         entry_count;
    logic               last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  zosl_in_if  in_ch ();
  zosl_out_if out_ch ();

  z_ordered_sorted_list u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cmd_t               cmd_queue[$];
  result_t            expected_results[$];
  logic [15:0]        held_ids[$];
  logic signed [15:0] held_keys[$];

  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit in_fire = 1'b0;
  bit idle_on = 1'b1;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit table_remove(logic [15:0] id);
    for (int i = 0; i < held_ids.size(); i++) begin
      if (held_ids[i] == id) begin
        held_ids.delete(i);
        held_keys.delete(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // lands after every entry with an equal key
  function automatic bit table_insert(logic [15:0] id, logic signed [15:0] key);
    int pos;
    if (held_ids.size() >= CAPACITY) return 1'b0;
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
    held_ids.insert(pos, id);
    held_keys.insert(pos, key);
    return 1'b1;
  endfunction

  function automatic bit table_holds(logic [15:0] id);
    foreach (held_ids[i]) if (held_ids[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void table_apply(logic [2:0] func, logic [15:0] id,
                                      logic signed [15:0] key);
    result_t r;
    bit      had;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (func)
      FN_INSERT: begin
        if (!table_insert(id, key)) r.status = ST_FULL;
      end
      FN_REMOVE: begin
        had = table_remove(id);
        r.found = had;
        if (!had) r.status = ST_ABSENT;
      end
      FN_FIND: begin
        had = table_holds(id);
        r.found = had;
        if (!had) r.status = ST_ABSENT;
      end
      FN_MOVE: begin
        r.found = table_remove(id);
        if (!table_insert(id, key)) r.status = ST_FULL;
      end
      FN_CLEAR: begin
        held_ids.delete();
        held_keys.delete();
      end
      FN_LIST: begin
        if (held_ids.size() != 0) begin
          foreach (held_ids[i]) begin
            r.entry_valid = 1'b1;
            r.entry_id    = held_ids[i];
            r.entry_key   = held_keys[i];
            r.entry_count = 6'(held_ids.size());
            r.last        = (i == held_ids.size() - 1);
            expected_results.insert(expected_results.size(), r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.entry_count = 6'(held_ids.size());
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic string result_str(result_t r);
    return $sformatf("status=%0d found=%0b valid=%0b id=%h key=%0d count=%0d last=%0b",
                     r.status, r.found, r.entry_valid, r.entry_id, r.entry_key,
                     r.entry_count, r.last);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_cmd(logic [2:0] func, logic [15:0] id,
                                   logic signed [15:0] key, bit drain = 1'b0);
    cmd_t c;
    c.func = func;
    c.item_id = id;
    c.depth_key = key;
    c.drain = drain;
    cmd_queue.insert(cmd_queue.size(), c);
  endfunction

  // mostly a small pool at both ends of the id range so lookups hit
  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: return ($urandom_range(0, 1) ? 16'hfff0 : 16'h0000) + 16'($urandom_range(0, 7));
    endcase
  endfunction

  // clustered keys give plenty of ties
  function automatic logic signed [15:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom);
      3:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(0, 6)) - 16'sd3;
    endcase
  endfunction

  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return FN_INSERT;
    if (r < 50) return FN_REMOVE;
    if (r < 65) return FN_FIND;
    if (r < 85) return FN_MOVE;
    if (r < 92) return FN_LIST;
    if (r < 94) return FN_CLEAR;
    return $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;
  endfunction

  // ---------------------------------------------------------------- driving

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // transaction still waiting for ready
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (cmd_queue.size() == 0 ||
                 (cmd_queue[0].drain && expected_results.size() != 0)) begin
      in_ch.valid <= 1'b0;
    end else if (idle_on && cmd_queue.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
      send_gap = $urandom_range(0, 3);
      in_ch.valid <= 1'b0;
    end else begin
      in_ch.valid     <= 1'b1;
      in_ch.func      <= cmd_queue[0].func;
      in_ch.item_id   <= cmd_queue[0].item_id;
      in_ch.depth_key <= cmd_queue[0].depth_key;
    end
  end

  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && cmd_queue.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
      recv_gap = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sampling

  always @(posedge clk) begin : sample
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status      = out_ch.status;
      got.found       = out_ch.found;
      got.entry_valid = out_ch.entry_valid;
      got.entry_id    = out_ch.entry_id;
      got.entry_key   = out_ch.entry_key;
      got.entry_count = out_ch.entry_count;
      got.last        = out_ch.last;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %s", $time, result_str(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                   $time, result_str(want), result_str(got));
        end
      end
    end
    // predict after checking, so results of this transaction never meet their own edge
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      table_apply(in_ch.func, in_ch.item_id, in_ch.depth_key);
      void'(cmd_queue.pop_front());
    end
    if (cycles % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.func      = FN_INSERT;
    in_ch.item_id   = '0;
    in_ch.depth_key = '0;
    out_ch.ready    = 1'b0;

    // empty table, absent ids, ties, duplicate ids, extremes
    push_cmd(FN_LIST,   16'h0000, 16'sh0000);
    push_cmd(FN_FIND,   16'h0005, 16'sh0000);
    push_cmd(FN_REMOVE, 16'h0005, 16'sh0000);
    push_cmd(FN_MOVE,   16'h0007, 16'sh0000);
    push_cmd(FN_INSERT, 16'h0000, 16'sh8000);
    push_cmd(FN_INSERT, 16'hffff, 16'sh7fff);
    push_cmd(FN_INSERT, 16'h0001, 16'sh0000);
    push_cmd(FN_INSERT, 16'h0001, 16'sh0000);
    push_cmd(FN_INSERT, 16'h0002, 16'shffff);
    push_cmd(FN_LIST,   16'h0000, 16'sh0000);
    push_cmd(FN_FIND,   16'h0001, 16'sh0000);
    push_cmd(FN_REMOVE, 16'h0001, 16'sh0000);
    push_cmd(FN_MOVE,   16'h0007, 16'sh7fff);
    push_cmd(FN_SPARE6, 16'h1234, 16'sh1234);
    push_cmd(FN_SPARE7, 16'hffff, 16'shffff);
    push_cmd(FN_LIST,   16'h0000, 16'sh0000);
    push_cmd(FN_CLEAR,  16'h0000, 16'sh0000);
    push_cmd(FN_LIST,   16'h0000, 16'sh0000);
    push_cmd(FN_FIND,   16'h0000, 16'sh0000);

    // fill past capacity, then move into a full table both ways
    push_cmd(FN_INSERT, 16'h00aa, 16'sd100);
    repeat (33) push_cmd(FN_INSERT, pick_id(), pick_key());
    push_cmd(FN_MOVE,   16'hbeef, 16'sh0000);
    push_cmd(FN_MOVE,   16'h00aa, 16'sh8000);
    push_cmd(FN_LIST,   16'h0000, 16'sh0000, 1'b1);
    push_cmd(FN_CLEAR,  16'h0000, 16'sh0000);

    while (cmd_queue.size() < NUM_CMDS) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(10, 40)) push_cmd(FN_INSERT, pick_id(), pick_key());
        2:    push_cmd(FN_LIST, pick_id(), pick_key());
        3:    push_cmd(FN_CLEAR, pick_id(), pick_key());
        default: begin
          repeat ($urandom_range(8, 24))
            push_cmd(pick_func(), pick_id(), pick_key(), $urandom_range(0, 49) == 0);
        end
      endcase
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/zosl_pkg.sv
hdl/zosl_if.sv
hdl/zosl_cell.sv
hdl/z_ordered_sorted_list.sv
dv/tb_z_ordered_sorted_list.sv
